// ===== rtl/pit_pkg.sv =====
package pit_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int GATE_CHAN    = 2;

	localparam logic [17:0] ELAPSED_MAX = 18'h3FFFF;
	localparam logic [16:0] FULL_COUNT  = 17'h10000;

	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_READ  = 2'd1,
		FN_WRITE = 2'd2
	} func_t;

	localparam logic [2:0] PORT_CTL  = 3'd3;
	localparam logic [2:0] PORT_GATE = 3'd4;
	localparam logic [1:0] SC_READBACK = 2'd3;
	localparam logic [1:0] RW_LATCH    = 2'd0;

	// byte order phases
	localparam logic [2:0] PH_LSB     = 3'd1;
	localparam logic [2:0] PH_MSB     = 3'd2;
	localparam logic [2:0] PH_WORD_LO = 3'd3;
	localparam logic [2:0] PH_WORD_HI = 3'd4;

	typedef struct packed {
		logic       en;
		logic       tick;
		logic       rd;
		logic       wr;
		logic       prog;
		logic       latch;
		logic       stat;
		logic       gate_wr;
		logic [7:0] wbyte;
	} chan_cmd_t;

	typedef struct packed {
		logic [7:0] rd_byte;
		logic       irq;
		logic       out;
		logic       gate;
	} chan_rsp_t;

endpackage

// ===== rtl/pit_chan.sv =====
module pit_chan (
	input  logic               clk,
	input  logic               arst_n,
	input  pit_pkg::chan_cmd_t cmd,
	output pit_pkg::chan_rsp_t rsp
);

	logic [16:0] reload_q, reload_n;
	logic [17:0] elapsed_q, elapsed_n;
	logic [16:0] rem_q, rem_n;     // elapsed mod reload, kept incrementally
	logic        wrapped_q, wrapped_n;
	logic [2:0]  mode_q, mode_n;
	logic [1:0]  access_q, access_n;
	logic        bcd_q, bcd_n;
	logic [2:0]  rphase_q, rphase_n;
	logic [2:0]  wphase_q, wphase_n;
	logic [7:0]  low_q, low_n;
	logic [15:0] hcount_q, hcount_n;
	logic [1:0]  hphase_q, hphase_n;
	logic [7:0]  hstatus_q, hstatus_n;
	logic        shold_q, shold_n;
	logic        run_q, run_n;
	logic        gate_q, gate_n;

	logic [2:0]  eff;
	logic [15:0] cur_live;
	logic        cur_out;
	logic [17:0] e_inc;
	logic [16:0] r_inc;
	logic [17:0] expiry;
	logic [15:0] load_val;
	logic        do_load;
	logic [7:0]  rd_byte;
	logic        irq;

	function automatic logic [15:0] live_fn(input logic [2:0] m, input logic [16:0] n,
		input logic [17:0] d, input logic [16:0] r);
		logic [17:0] n18, r18, t, t2, d1, v;
		begin
			n18 = {1'b0, n};
			r18 = {1'b0, r};
			t   = {r, 1'b0};
			t2  = (t >= n18) ? t - n18 : t;
			d1  = (n18 + 18'd1) >> 1;
			v   = 18'd0;
			if (n != 17'd0) begin
				unique case (m)
					3'd2: v = n18 - r18;
					3'd3: begin
						if (!n[0]) v = n18 - t2;
						else       v = (r18 < d1) ? d1 - r18 : r18 - d1;
					end
					default: v = (n18 > d) ? n18 - d : 18'd0;
				endcase
			end
			live_fn = v[15:0];
		end
	endfunction

	function automatic logic out_fn(input logic [2:0] m, input logic [16:0] n,
		input logic [17:0] d, input logic [16:0] r, input logic w);
		logic [17:0] n18, half;
		logic        o;
		begin
			n18  = {1'b0, n};
			half = (n18 + 18'd1) >> 1;
			o    = 1'b0;
			if (n != 17'd0) begin
				unique case (m)
					3'd0: o = (d >= n18);
					3'd1: o = (d < n18);
					3'd2: o = (r == 17'd0) && ((d != 18'd0) || w);
					3'd3: o = ({1'b0, r} < half);
					3'd4, 3'd5: o = (d == n18);
					default: o = 1'b0;
				endcase
			end
			out_fn = o;
		end
	endfunction

	// modes 6 and 7 behave as 2 and 3
	assign eff      = (mode_q[2:1] == 2'b11) ? {1'b0, mode_q[1:0]} : mode_q;
	assign cur_live = live_fn(eff, reload_q, elapsed_q, rem_q);
	assign cur_out  = out_fn(eff, reload_q, elapsed_q, rem_q, wrapped_q);

	always_comb begin
		e_inc = elapsed_q;
		r_inc = rem_q;
		if (elapsed_q != pit_pkg::ELAPSED_MAX) begin
			e_inc = elapsed_q + 18'd1;
			if (reload_q != 17'd0)
				r_inc = (rem_q + 17'd1 == reload_q) ? 17'd0 : rem_q + 17'd1;
		end
		expiry = eff[2] ? {1'b0, reload_q} + 18'd1 : {1'b0, reload_q};
	end

	always_comb begin
		reload_n  = reload_q;  elapsed_n = elapsed_q; rem_n     = rem_q;
		wrapped_n = wrapped_q; mode_n    = mode_q;    access_n  = access_q;
		bcd_n     = bcd_q;     rphase_n  = rphase_q;  wphase_n  = wphase_q;
		low_n     = low_q;     hcount_n  = hcount_q;  hphase_n  = hphase_q;
		hstatus_n = hstatus_q; shold_n   = shold_q;   run_n     = run_q;
		gate_n    = gate_q;
		rd_byte   = 8'd0;
		irq       = 1'b0;
		do_load   = 1'b0;
		load_val  = 16'd0;

		if (cmd.en) begin
			if (cmd.tick) begin
				elapsed_n = e_inc;
				rem_n     = r_inc;
				if (run_q && reload_q != 17'd0 && e_inc >= expiry) begin
					irq = 1'b1;
					if (eff[2:1] == 2'b01) begin
						elapsed_n = {1'b0, r_inc};
						wrapped_n = 1'b1;
					end else begin
						run_n = 1'b0;
					end
				end
			end

			if (cmd.rd) begin
				priority if (shold_q) begin
					rd_byte = hstatus_q;
					shold_n = 1'b0;
				end else if (hphase_q != 2'd0) begin
					unique case (hphase_q)
						2'd1: begin rd_byte = hcount_q[7:0];  hphase_n = 2'd0; end
						2'd2: begin rd_byte = hcount_q[15:8]; hphase_n = 2'd0; end
						default: begin rd_byte = hcount_q[7:0]; hphase_n = 2'd2; end
					endcase
				end else begin
					unique case (rphase_q)
						pit_pkg::PH_LSB: rd_byte = cur_live[7:0];
						pit_pkg::PH_MSB: rd_byte = cur_live[15:8];
						pit_pkg::PH_WORD_LO: begin
							rd_byte  = cur_live[7:0];
							rphase_n = pit_pkg::PH_WORD_HI;
						end
						pit_pkg::PH_WORD_HI: begin
							rd_byte  = cur_live[15:8];
							rphase_n = pit_pkg::PH_WORD_LO;
						end
						default: rd_byte = 8'd0;
					endcase
				end
			end

			if (cmd.wr) begin
				unique case (wphase_q)
					pit_pkg::PH_LSB: begin do_load = 1'b1; load_val = {8'd0, cmd.wbyte}; end
					pit_pkg::PH_MSB: begin do_load = 1'b1; load_val = {cmd.wbyte, 8'd0}; end
					pit_pkg::PH_WORD_LO: begin
						low_n    = cmd.wbyte;
						wphase_n = pit_pkg::PH_WORD_HI;
					end
					pit_pkg::PH_WORD_HI: begin
						do_load  = 1'b1;
						load_val = {cmd.wbyte, low_q};
						wphase_n = pit_pkg::PH_WORD_LO;
					end
					default: ;
				endcase
				if (do_load) begin
					reload_n  = (load_val == 16'd0) ? pit_pkg::FULL_COUNT : {1'b0, load_val};
					elapsed_n = 18'd0;
					rem_n     = 17'd0;
					wrapped_n = 1'b0;
					run_n     = 1'b1;
				end
			end

			if (cmd.prog) begin
				access_n = cmd.wbyte[5:4];
				rphase_n = {1'b0, cmd.wbyte[5:4]};
				wphase_n = {1'b0, cmd.wbyte[5:4]};
				mode_n   = cmd.wbyte[3:1];
				bcd_n    = cmd.wbyte[0];
			end

			if (cmd.latch && hphase_q == 2'd0) begin
				hcount_n = cur_live;
				hphase_n = access_q;
			end

			if (cmd.stat && !shold_q) begin
				hstatus_n = {cur_out, 1'b0, access_q, mode_q, bcd_q};
				shold_n   = 1'b1;
			end

			if (cmd.gate_wr) begin
				if (eff != 3'd0 && eff != 3'd4 && !gate_q && cmd.wbyte[0]) begin
					elapsed_n = 18'd0;
					rem_n     = 17'd0;
					wrapped_n = 1'b0;
					if (reload_q != 17'd0) run_n = 1'b1;
				end
				gate_n = cmd.wbyte[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q  <= '0; elapsed_q <= '0; rem_q    <= '0; wrapped_q <= 1'b0;
			mode_q    <= '0; access_q  <= '0; bcd_q    <= 1'b0;
			rphase_q  <= '0; wphase_q  <= '0; low_q    <= '0;
			hcount_q  <= '0; hphase_q  <= '0; hstatus_q <= '0; shold_q <= 1'b0;
			run_q     <= 1'b0; gate_q  <= 1'b0;
		end else begin
			reload_q  <= reload_n;  elapsed_q <= elapsed_n; rem_q     <= rem_n;
			wrapped_q <= wrapped_n; mode_q    <= mode_n;    access_q  <= access_n;
			bcd_q     <= bcd_n;     rphase_q  <= rphase_n;  wphase_q  <= wphase_n;
			low_q     <= low_n;     hcount_q  <= hcount_n;  hphase_q  <= hphase_n;
			hstatus_q <= hstatus_n; shold_q   <= shold_n;   run_q     <= run_n;
			gate_q    <= gate_n;
		end
	end

	// out level after this word, using the mode as it will stand
	always_comb begin
		rsp.rd_byte = rd_byte;
		rsp.irq     = irq;
		rsp.out     = out_fn((mode_n[2:1] == 2'b11) ? {1'b0, mode_n[1:0]} : mode_n,
			reload_n, elapsed_n, rem_n, wrapped_n);
		rsp.gate    = gate_q;
	end

endmodule

// ===== rtl/interval_timer_8254_unit.sv =====
// three-channel interval timer, one result word per input word
// each word passes through the input register, then the result register
// throughput: one word per cycle while the output is not stalled; the per-channel update is a single pass of logic
// between the input register and the result register
// reset: arst_n clears all channel state, both stage valids and the result register
module interval_timer_8254_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // wdata[7:0]
	input  logic [4:0]  s_tuser,   // func[1:0], port_sel[4:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // read_data[7:0], irq_mask[10:8], out_bits[13:11], zero
);

	// input register
	logic       vld_s1;
	logic [1:0] func_s1;
	logic [2:0] port_s1;
	logic [7:0] wdata_s1;

	// result register
	logic        vld_s2;
	logic [15:0] res_s2;

	logic adv;   // stage 1 word is processed and moves into the result register

	pit_pkg::chan_cmd_t cmd [pit_pkg::NUM_CHANNELS];
	pit_pkg::chan_rsp_t rsp [pit_pkg::NUM_CHANNELS];

	logic [2:0] irq_mask;
	logic [2:0] out_bits;
	logic [2:0] gate_bits;
	logic [7:0] read_data;
	logic [7:0] chan_rd [3];

	logic is_tick, is_read, is_write;
	logic [1:0] sc, rw;

	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	assign is_tick  = (func_s1 == pit_pkg::FN_TICK);
	assign is_read  = (func_s1 == pit_pkg::FN_READ);
	assign is_write = (func_s1 == pit_pkg::FN_WRITE);
	assign sc       = wdata_s1[7:6];
	assign rw       = wdata_s1[5:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1  <= s_tuser[1:0];
			port_s1  <= s_tuser[4:2];
			wdata_s1 <= s_tdata;
		end
	end

	// per-channel command decode and channel instances
	for (genvar c = 0; c < 3; c++) begin : g_chan
		if (c < pit_pkg::NUM_CHANNELS) begin : g_on
			always_comb begin
				cmd[c].en      = adv;
				cmd[c].tick    = is_tick;
				cmd[c].rd      = is_read && (port_s1 == 3'(c));
				cmd[c].wr      = is_write && (port_s1 == 3'(c));
				// control word aimed at this channel that is not a counter latch: program
				cmd[c].prog    = is_write && (port_s1 == pit_pkg::PORT_CTL) &&
					(sc == 2'(c)) && (rw != pit_pkg::RW_LATCH);
				// latch via counter latch command or read-back with count bit low
				cmd[c].latch   = is_write && (port_s1 == pit_pkg::PORT_CTL) &&
					(((sc == 2'(c)) && (rw == pit_pkg::RW_LATCH)) ||
					((sc == pit_pkg::SC_READBACK) && wdata_s1[c+1] && !wdata_s1[5]));
				cmd[c].stat    = is_write && (port_s1 == pit_pkg::PORT_CTL) &&
					(sc == pit_pkg::SC_READBACK) && wdata_s1[c+1] && !wdata_s1[4];
				cmd[c].gate_wr = is_write && (port_s1 == pit_pkg::PORT_GATE) &&
					(c == pit_pkg::GATE_CHAN);
				cmd[c].wbyte   = wdata_s1;
			end

			pit_chan u_chan (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd[c]),
				.rsp    (rsp[c])
			);

			assign chan_rd[c]   = rsp[c].rd_byte;
			assign irq_mask[c]  = rsp[c].irq;
			assign out_bits[c]  = rsp[c].out;
			assign gate_bits[c] = rsp[c].gate;
		end else begin : g_off
			assign chan_rd[c]   = 8'd0;
			assign irq_mask[c]  = 1'b0;
			assign out_bits[c]  = 1'b0;
			assign gate_bits[c] = 1'b0;
		end
	end

	// only the addressed channel returns a nonzero byte; gate port reads out and gate
	always_comb begin
		read_data = chan_rd[0] | chan_rd[1] | chan_rd[2];
		if (is_read && port_s1 == pit_pkg::PORT_GATE && pit_pkg::GATE_CHAN < pit_pkg::NUM_CHANNELS)
			read_data = {2'b00, out_bits[pit_pkg::GATE_CHAN], 4'b0000,
				gate_bits[pit_pkg::GATE_CHAN]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			res_s2 <= '0;
		end else begin
			if (adv) begin
				vld_s2 <= 1'b1;
				res_s2 <= {2'b00, out_bits, irq_mask, read_data};
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = res_s2;

endmodule
